// ===== rtl/tli_pkg.sv =====
// Shared types and codes for the table linear interpolator.
`timescale 1ns / 1ps

package tli_pkg;

   localparam int VAL_W    = 32;
   localparam int INDEX_W  = 6;
   localparam int LEN_W    = 7;
   localparam int STATUS_W = 2;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_EXACT  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INTERP = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_DEGEN  = 2'd3;

   typedef struct packed {
      logic [VAL_W-1:0]        energy;
      logic signed [VAL_W-1:0] flux;
   } entry_type;

   // Segment endpoints: lo is the predecessor, hi the first entry above the query.
   typedef struct packed {
      entry_type lo;
      entry_type hi;
   } seg_type;

   typedef struct packed {
      logic                    kind;
      logic [INDEX_W-1:0]      entry_index;
      logic [VAL_W-1:0]        entry_energy;
      logic signed [VAL_W-1:0] entry_flux;
      logic [VAL_W-1:0]        query_energy;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] flux_value;
      logic [STATUS_W-1:0]     status;
   } rsp_type;

endpackage

// ===== rtl/table_linear_interpolator.sv =====
// Top level of the table linear interpolator: breakpoint chain, scan and result.
// Holds TABLE_DEPTH energy/flux breakpoints in a ring of cells. A load item
// (kind 0) writes one slot; slots at or beyond TABLE_DEPTH are dropped. A
// query item (kind 1) rotates the whole ring once past a head comparator,
// so the table is back in place afterward; the first entry equal to the
// query energy gives status 0 with its flux, otherwise the first entry
// above the query (from index 1) and its predecessor form the segment.
// Flat segments give status 3, no segment gives status 2; both with flux 0.
// An interpolation then runs two shared multiplies, a 67-bit sum and
// magnitude, and a 32-step restoring divider. The ring rotation sets how
// long a query takes, and for an interpolation also the bit-serial divider,
// which is skipped when the quotient is known to saturate; a full output
// register holds a finished query back until the consumer takes the older
// result. One item is in progress at a time; the next item is taken once
// the previous result has been moved into the output register, even if the
// consumer has not yet taken it. A load yields no result. csr_wr_data sets
// the number of live entries (reset 1); values above TABLE_DEPTH act as
// TABLE_DEPTH. Write it only while the block is idle. Entries read by a
// query must have been loaded first; storage has no reset.
`timescale 1ns / 1ps

module table_linear_interpolator #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tli_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tli_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [tli_pkg::LEN_W-1:0]        csr_wr_data
);

   localparam int VW    = tli_pkg::VAL_W;
   localparam int POS_W = $clog2(TABLE_DEPTH);
   localparam int CMP_W = ((POS_W > tli_pkg::LEN_W) ? POS_W : tli_pkg::LEN_W) + 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(TABLE_DEPTH - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_CALC   = 3'd3;
   localparam logic [2:0] S_POST   = 3'd4;

   logic [2:0]                  state_ff,  state_in;
   logic [tli_pkg::LEN_W-1:0]   len_ff,    len_in;
   logic [POS_W-1:0]            pos_ff,    pos_in;
   logic [VW-1:0]               qe_ff,     qe_in;
   logic                        match_ff,  match_in;
   logic signed [VW-1:0]        mflux_ff,  mflux_in;
   logic                        above_ff,  above_in;
   tli_pkg::seg_type            seg_ff,    seg_in;
   tli_pkg::entry_type          prev_ff,   prev_in;
   tli_pkg::rsp_type            res_ff,    res_in;
   logic                        rvalid_ff, rvalid_in;
   tli_pkg::rsp_type            rdata_ff,  rdata_in;

   tli_pkg::entry_type          cell_q [TABLE_DEPTH];
   tli_pkg::entry_type          head;
   tli_pkg::entry_type          load_entry;
   logic                        accept;
   logic                        load_fire;
   logic                        shift_en;
   logic                        in_len;
   logic                        calc_start;
   logic                        calc_done;
   logic signed [VW-1:0]        calc_flux;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_fire = accept && (req_data.kind == tli_pkg::KIND_LOAD);
   assign shift_en  = (state_ff == S_SCAN);

   assign load_entry.energy = req_data.entry_energy;
   assign load_entry.flux   = req_data.entry_flux;

   // Ring of cells: each hands its entry to its lower neighbor while a query
   // scans; cell 0 is the head seen by the comparators and wraps to the top.
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      localparam int NEXT = (i + 1) % TABLE_DEPTH;
      tli_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .shift_in (cell_q[NEXT]),
         .load_en  (load_fire && (32'(req_data.entry_index) == 32'(i))),
         .load_in  (load_entry),
         .entry    (cell_q[i])
      );
   end

   assign head   = cell_q[0];
   // head holds entry pos_ff during the scan
   assign in_len = CMP_W'(pos_ff) < CMP_W'(len_ff);

   assign calc_start = (state_ff == S_DECIDE) && !match_ff && above_ff
                       && (seg_ff.lo.energy != seg_ff.hi.energy);

   tli_interp u_interp (
      .clock        (clock),
      .reset        (reset),
      .start        (calc_start),
      .seg          (seg_ff),
      .query_energy (qe_ff),
      .done         (calc_done),
      .flux         (calc_flux)
   );

   always_comb begin
      state_in  = state_ff;
      len_in    = csr_wr_en ? csr_wr_data : len_ff;
      pos_in    = pos_ff;
      qe_in     = qe_ff;
      match_in  = match_ff;
      mflux_in  = mflux_ff;
      above_in  = above_ff;
      seg_in    = seg_ff;
      prev_in   = prev_ff;
      res_in    = res_ff;
      rvalid_in = rvalid_ff;
      rdata_in  = rdata_ff;

      // output register drains independently of the core
      if (rvalid_ff && rsp_ready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.kind == tli_pkg::KIND_QUERY) begin
               qe_in    = req_data.query_energy;
               pos_in   = '0;
               match_in = 1'b0;
               above_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // first equal entry wins over any segment
            if (in_len && !match_ff && head.energy == qe_ff) begin
               match_in = 1'b1;
               mflux_in = head.flux;
            end
            if (in_len && !above_ff && pos_ff != '0 && head.energy > qe_ff) begin
               above_in = 1'b1;
               seg_in.lo = prev_ff;
               seg_in.hi = head;
            end
            prev_in = head;
            pos_in  = pos_ff + 1'b1;
            if (pos_ff == POS_LAST) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (match_ff) begin
               res_in.flux_value = mflux_ff;
               res_in.status     = tli_pkg::STATUS_EXACT;
               state_in          = S_POST;
            end else if (!above_ff) begin
               res_in.flux_value = '0;
               res_in.status     = tli_pkg::STATUS_RANGE;
               state_in          = S_POST;
            end else if (seg_ff.lo.energy == seg_ff.hi.energy) begin
               res_in.flux_value = '0;
               res_in.status     = tli_pkg::STATUS_DEGEN;
               state_in          = S_POST;
            end else begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (calc_done) begin
               res_in.flux_value = calc_flux;
               res_in.status     = tli_pkg::STATUS_INTERP;
               state_in          = S_POST;
            end
         end
         S_POST: begin
            if (!rvalid_ff || rsp_ready) begin
               rvalid_in = 1'b1;
               rdata_in  = res_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= tli_pkg::LEN_W'(1);
         rvalid_ff <= 1'b0;
         pos_ff    <= '0;
         match_ff  <= 1'b0;
         above_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         rvalid_ff <= rvalid_in;
         pos_ff    <= pos_in;
         match_ff  <= match_in;
         above_ff  <= above_in;
      end
   end

   always_ff @(posedge clock) begin
      qe_ff    <= qe_in;
      mflux_ff <= mflux_in;
      seg_ff   <= seg_in;
      prev_ff  <= prev_in;
      res_ff   <= res_in;
      rdata_ff <= rdata_in;
   end

   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rdata_ff;

`ifndef SYNTHESIS
   // a full rotation always ends in the decision step
   a_scan_wraps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && pos_ff == POS_LAST) |=> (state_ff == S_DECIDE))
      else $error("scan did not end after one full rotation");

   // the divider only reports while the core waits for it
   a_calc_done_owned: assert property (@(posedge clock) disable iff (reset)
      calc_done |-> (state_ff == S_CALC))
      else $error("interpolation finished outside the calc state");

   // a new result only appears out of the post state
   a_rsp_from_post: assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> ($past(state_ff) == S_POST))
      else $error("result valid raised outside the post state");

   // flagged results carry zero flux
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rvalid_ff && (rdata_ff.status == tli_pkg::STATUS_RANGE
                     || rdata_ff.status == tli_pkg::STATUS_DEGEN))
      |-> (rdata_ff.flux_value == '0))
      else $error("flagged result with nonzero flux");
`endif

endmodule

// ===== rtl/tli_cell.sv =====
// One breakpoint cell of the rotating table chain.
`timescale 1ns / 1ps

module tli_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  tli_pkg::entry_type shift_in,
   input  logic               load_en,
   input  tli_pkg::entry_type load_in,
   output tli_pkg::entry_type entry
);

   tli_pkg::entry_type entry_ff;
   tli_pkg::entry_type entry_in;

   // rotation wins; loads only happen while the chain is parked
   always_comb begin
      entry_in = entry_ff;
      if (shift_en) begin
         entry_in = shift_in;
      end else if (load_en) begin
         entry_in = load_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/tli_interp.sv =====
// Segment interpolation: shared multiplier, sum, magnitude and bit-serial divider.
`timescale 1ns / 1ps

module tli_interp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  tli_pkg::seg_type                    seg,
   input  logic [tli_pkg::VAL_W-1:0]           query_energy,
   output logic                                done,
   output logic signed [tli_pkg::VAL_W-1:0]    flux
);

   localparam int VW    = tli_pkg::VAL_W;
   localparam int DW    = VW + 1;
   localparam int PW    = 2 * DW;
   localparam int SW    = PW + 1;
   localparam int CNT_W = $clog2(VW);

   localparam logic [2:0] I_IDLE = 3'd0;
   localparam logic [2:0] I_MUL1 = 3'd1;
   localparam logic [2:0] I_MUL2 = 3'd2;
   localparam logic [2:0] I_SUM  = 3'd3;
   localparam logic [2:0] I_ABS  = 3'd4;
   localparam logic [2:0] I_CHK  = 3'd5;
   localparam logic [2:0] I_DIV  = 3'd6;
   localparam logic [2:0] I_FIN  = 3'd7;

   localparam logic [VW-1:0] MAX_POS = {1'b0, {(VW-1){1'b1}}};
   localparam logic [VW-1:0] MIN_NEG = {1'b1, {(VW-1){1'b0}}};

   logic [2:0]              st_ff,   st_in;
   logic signed [DW-1:0]    den_ff,  den_in;
   logic signed [DW-1:0]    df_ff,   df_in;
   logic signed [DW-1:0]    dq_ff,   dq_in;
   logic signed [DW-1:0]    f1_ff,   f1_in;
   logic signed [PW-1:0]    p1_ff,   p1_in;
   logic signed [PW-1:0]    p2_ff,   p2_in;
   logic signed [SW-1:0]    tot_ff,  tot_in;
   logic [SW-1:0]           mag_ff,  mag_in;
   logic                    rneg_ff, rneg_in;
   logic [VW-1:0]           dmag_ff, dmag_in;
   logic                    big_ff,  big_in;
   logic [VW-1:0]           rem_ff,  rem_in;
   logic [VW-1:0]           quo_ff,  quo_in;
   logic [CNT_W-1:0]        cnt_ff,  cnt_in;

   logic signed [DW-1:0]    mul_a;
   logic signed [DW-1:0]    mul_b;
   logic signed [PW-1:0]    prod;
   logic signed [DW-1:0]    den_abs;
   logic [DW-1:0]           trial;
   logic [DW-1:0]           trial_diff;
   logic                    trial_ge;

   // one multiplier, used for f1*den then (f2-f1)*(q-e1)
   assign mul_a = (st_ff == I_MUL1) ? f1_ff  : df_ff;
   assign mul_b = (st_ff == I_MUL1) ? den_ff : dq_ff;
   assign prod  = mul_a * mul_b;

   assign den_abs    = den_ff[DW-1] ? -den_ff : den_ff;
   assign trial      = {rem_ff, quo_ff[VW-1]};
   assign trial_diff = trial - {1'b0, dmag_ff};
   assign trial_ge   = trial >= {1'b0, dmag_ff};

   always_comb begin
      st_in   = st_ff;
      den_in  = den_ff;
      df_in   = df_ff;
      dq_in   = dq_ff;
      f1_in   = f1_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      tot_in  = tot_ff;
      mag_in  = mag_ff;
      rneg_in = rneg_ff;
      dmag_in = dmag_ff;
      big_in  = big_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      case (st_ff)
         I_IDLE: begin
            if (start) begin
               den_in = $signed({1'b0, seg.hi.energy}) - $signed({1'b0, seg.lo.energy});
               df_in  = DW'(seg.hi.flux) - DW'(seg.lo.flux);
               dq_in  = $signed({1'b0, query_energy}) - $signed({1'b0, seg.lo.energy});
               f1_in  = DW'(seg.lo.flux);
               st_in  = I_MUL1;
            end
         end
         I_MUL1: begin
            p1_in = prod;
            st_in = I_MUL2;
         end
         I_MUL2: begin
            p2_in = prod;
            st_in = I_SUM;
         end
         I_SUM: begin
            tot_in = SW'(p1_ff) + SW'(p2_ff);
            st_in  = I_ABS;
         end
         I_ABS: begin
            mag_in  = tot_ff[SW-1] ? SW'(-tot_ff) : SW'(tot_ff);
            rneg_in = tot_ff[SW-1] ^ den_ff[DW-1];
            dmag_in = den_abs[VW-1:0];
            st_in   = I_CHK;
         end
         I_CHK: begin
            // quotient of 2^VW or more saturates without dividing
            big_in = mag_ff[SW-1:VW] >= (SW-VW)'(dmag_ff);
            rem_in = mag_ff[2*VW-1:VW];
            quo_in = mag_ff[VW-1:0];
            cnt_in = '0;
            st_in  = (mag_ff[SW-1:VW] >= (SW-VW)'(dmag_ff)) ? I_FIN : I_DIV;
         end
         I_DIV: begin
            rem_in = trial_ge ? trial_diff[VW-1:0] : trial[VW-1:0];
            quo_in = {quo_ff[VW-2:0], trial_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VW - 1)) begin
               st_in = I_FIN;
            end
         end
         I_FIN: begin
            st_in = I_IDLE;
         end
         default: begin
            st_in = I_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= I_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      df_ff   <= df_in;
      dq_ff   <= dq_in;
      f1_ff   <= f1_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      tot_ff  <= tot_in;
      mag_ff  <= mag_in;
      rneg_ff <= rneg_in;
      dmag_ff <= dmag_in;
      big_ff  <= big_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   // sign and saturate the magnitude quotient
   always_comb begin
      if (rneg_ff) begin
         flux = (big_ff || quo_ff > MIN_NEG) ? $signed(MIN_NEG) : $signed(-quo_ff);
      end else begin
         flux = (big_ff || quo_ff > MAX_POS) ? $signed(MAX_POS) : $signed(quo_ff);
      end
   end

   assign done = (st_ff == I_FIN);

endmodule

// ===== tb/tb_table_linear_interpolator.sv =====
// Testbench for table_linear_interpolator: directed and random load/query traffic with a predictor.
`timescale 1ns / 1ps

module tb_table_linear_interpolator;

   localparam int CLOCK_PERIOD = 10;
   localparam int TABLE_DEPTH  = 64;
   localparam int VAL_W        = tli_pkg::VAL_W;
   localparam int INDEX_W      = tli_pkg::INDEX_W;
   localparam int LEN_W        = tli_pkg::LEN_W;
   // Random part starts no new phase once this many items have been sent.
   localparam int RANDOM_ITEMS = 500;
   // Wait this long after the last result before touching the register.
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 110;
   // Room for about 600 items at their worst case each, plus phase pauses, taken several times over.
   localparam int LIMIT_CYCLES = 800000;

   // Saturation bounds of the result, held at the width of the wide arithmetic.
   localparam logic signed [127:0] SAT_HI = 128'sd2147483647;
   localparam logic signed [127:0] SAT_LO = -128'sd2147483648;

   // Receiver back-pressure patterns.
   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_BURSTS
   } ready_mode_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   tli_pkg::req_type  req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   tli_pkg::rsp_type  rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [LEN_W-1:0]  csr_wr_data = '0;

   // Predictor copy of the breakpoint table and the length register.
   logic [VAL_W-1:0]        knot_energy [TABLE_DEPTH];
   logic signed [VAL_W-1:0] knot_flux   [TABLE_DEPTH];
   int                      live_length = 1;

   // Results owed by the block, oldest first.
   tli_pkg::rsp_type pending_results [$];

   int             error_count = 0;
   int             cycle_count = 0;
   int             burst_left  = 0;
   ready_mode_type ready_mode  = READY_ALWAYS;
   int             stall_left  = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   table_linear_interpolator #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Result of a query against the current table: exact hit first, then the
   // first entry above the query (from index 1) with its predecessor.
   function automatic tli_pkg::rsp_type interpolate_flux(input logic [VAL_W-1:0] probe);
      tli_pkg::rsp_type    res;
      int                  span_count;
      logic signed [127:0] e_lo, e_hi, f_lo, f_hi, q_e, width, total, quot;
      res.flux_value = '0;
      res.status     = tli_pkg::STATUS_RANGE;
      // Lengths above the table depth act as the full table.
      span_count = (live_length > TABLE_DEPTH) ? TABLE_DEPTH : live_length;
      for (int i = 0; i < span_count; i++) begin
         if (knot_energy[i] == probe) begin
            res.flux_value = knot_flux[i];
            res.status     = tli_pkg::STATUS_EXACT;
            return res;
         end
      end
      for (int i = 1; i < span_count; i++) begin
         if (knot_energy[i] > probe) begin
            e_lo  = {96'b0, knot_energy[i - 1]};
            e_hi  = {96'b0, knot_energy[i]};
            f_lo  = knot_flux[i - 1];
            f_hi  = knot_flux[i];
            q_e   = {96'b0, probe};
            width = e_hi - e_lo;
            // Flat segment: nothing to divide by.
            if (width == 0) begin
               res.status = tli_pkg::STATUS_DEGEN;
               return res;
            end
            // f_lo + (f_hi - f_lo)(q - e_lo)/width over one common denominator;
            // signed division truncates toward zero. A predecessor above the
            // entry just gives a negative width.
            total = f_lo * width + (f_hi - f_lo) * (q_e - e_lo);
            quot  = total / width;
            if (quot > SAT_HI)
               res.flux_value = 32'h7FFF_FFFF;
            else if (quot < SAT_LO)
               res.flux_value = 32'h8000_0000;
            else
               res.flux_value = quot[VAL_W-1:0];
            res.status = tli_pkg::STATUS_INTERP;
            return res;
         end
      end
      return res;
   endfunction

   // Apply an accepted item: a load updates the table, a query owes one result.
   function automatic void absorb_item(input tli_pkg::req_type item);
      if (item.kind == tli_pkg::KIND_LOAD) begin
         knot_energy[item.entry_index] = item.entry_energy;
         knot_flux[item.entry_index]   = item.entry_flux;
      end else begin
         pending_results = {pending_results, interpolate_flux(item.query_energy)};
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Item builders; the fields a kind does not use carry noise.
   // ---------------------------------------------------------------------------

   function automatic tli_pkg::req_type make_load(input int slot,
                                                  input logic [VAL_W-1:0] energy,
                                                  input logic signed [VAL_W-1:0] flux);
      tli_pkg::req_type item;
      item.kind         = tli_pkg::KIND_LOAD;
      item.entry_index  = INDEX_W'(slot);
      item.entry_energy = energy;
      item.entry_flux   = flux;
      item.query_energy = $urandom();
      return item;
   endfunction

   function automatic tli_pkg::req_type make_query(input logic [VAL_W-1:0] probe);
      tli_pkg::req_type item;
      item.kind         = tli_pkg::KIND_QUERY;
      item.entry_index  = INDEX_W'($urandom());
      item.entry_energy = $urandom();
      item.entry_flux   = $urandom();
      item.query_energy = probe;
      return item;
   endfunction

   // Half full-scale values, half small values around zero.
   function automatic logic signed [VAL_W-1:0] random_flux();
      if ($urandom_range(0, 1) == 1)
         return $urandom();
      return $urandom_range(0, 200000) - 100000;
   endfunction

   // ---------------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------------

   // Called and returns at a falling edge. Items go out in bursts; between
   // bursts valid drops for a random gap. Valid stays high after acceptance so
   // a back-to-back item needs only one assignment in that step.
   task automatic send_item(input tli_pkg::req_type item);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 30);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do
         @(posedge clock);
      while (!req_ready);
      absorb_item(item);
      burst_left--;
      @(negedge clock);
   endtask

   // Stop sending, wait for every owed result, then let the block fall idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Length register write, only ever with the block idle.
   task automatic write_length(input int value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LEN_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      live_length = value;
   endtask

   // ---------------------------------------------------------------------------
   // Receiver side: ready pattern changes mode now and then
   // ---------------------------------------------------------------------------

   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0)
         ready_mode = ready_mode_type'($urandom_range(READY_ALWAYS, READY_BURSTS));
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_ready <= 1'b1;
         end
         READY_COIN: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready <= 1'b0;
            end else begin
               if ($urandom_range(0, 3) == 0)
                  stall_left = $urandom_range(1, 12);
               rsp_ready <= 1'b1;
            end
         end
      endcase
   end

   // Each accepted result against the oldest owed one, field by field.
   always @(posedge clock) begin : check_results
      tli_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got flux_value %0d status %0d",
                     $time, rsp_data.flux_value, rsp_data.status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.flux_value !== want.flux_value) begin
               $display("%0t: flux_value expected %0d, got %0d",
                        $time, want.flux_value, rsp_data.flux_value);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d",
                        $time, want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t: cycle limit reached with %0d results owed",
                  $time, pending_results.size());
         $display("FAIL table_linear_interpolator");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Reset length of one entry: hit at energy zero, miss at full scale, then
   // an empty table.
   task automatic test_single_entry();
      send_item(make_load(0, 32'h0000_0000, 32'h8000_0000));
      send_item(make_query(32'h0000_0000));
      send_item(make_query(32'hFFFF_FFFF));
      write_length(0);
      send_item(make_query(32'h0000_0000));
   endtask

   // Plain interpolation, extrapolation below the first entry, truncation.
   task automatic test_interpolation();
      write_length(3);
      send_item(make_load(0, 32'h0001_0000, -7));
      send_item(make_load(1, 32'h0003_0000, 10));
      send_item(make_load(2, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      send_item(make_query(32'h0002_0000));   // 1.5 -> 1
      send_item(make_query(32'h0000_8000));   // below entry 0: -11.25 -> -11
      send_item(make_query(32'h8000_0000));   // wide second segment
      send_item(make_query(32'h0003_0000));   // lands on a breakpoint
   endtask

   // Extreme slope pushed far outside the segment, both directions.
   task automatic test_saturation();
      write_length(2);
      send_item(make_load(0, 100, 32'h7FFF_FFFF));
      send_item(make_load(1, 101, 32'h8000_0000));
      send_item(make_query(0));                // clips high
      send_item(make_load(0, 100, 32'h8000_0000));
      send_item(make_load(1, 101, 32'h7FFF_FFFF));
      send_item(make_query(0));                // clips low
   endtask

   // Flat segment, a dip in the table, no entry above, negative width.
   task automatic test_segment_shapes();
      write_length(4);
      send_item(make_load(0, 500, 1));
      send_item(make_load(1, 500, 2));
      send_item(make_load(2, 300, 5));
      send_item(make_load(3, 900, -5));
      send_item(make_query(200));              // entries 0 and 1 equal: flat
      send_item(make_query(700));              // skips the dip, uses entries 2..3
      send_item(make_query(1000));             // nothing above
      send_item(make_load(0, 800, 40));
      send_item(make_query(100));              // predecessor above entry 1
   endtask

   // Phases of: length write, fresh table, then queries with the odd reload.
   task automatic test_random_tables();
      int                      sent, phase, length, live, style, n_queries, pick, idx, step;
      bit                      descending;
      logic [VAL_W-1:0]        energies [$];
      logic [VAL_W-1:0]        probe, lo, hi;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         // Open with the largest setting and the table depth, then mostly short tables.
         if (phase == 0)
            length = 127;
         else if (phase == 1)
            length = TABLE_DEPTH;
         else begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               length = 0;
            else if (pick == 1)
               length = 1;
            else if (pick == 2)
               length = $urandom_range(TABLE_DEPTH, 127);
            else
               length = $urandom_range(2, 12);
         end
         write_length(length);
         live = (length > TABLE_DEPTH) ? TABLE_DEPTH : length;

         // Table shape: sorted full range, dense ramps, sorted with repeats,
         // or unsorted.
         style = $urandom_range(0, 9);
         energies.delete();
         if (style >= 5 && style <= 7) begin
            energies = {energies, VAL_W'($urandom())};
            for (int k = 1; k < live; k++) begin
               step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4096);
               energies = {energies, energies[k - 1] + VAL_W'(step)};
            end
         end else begin
            for (int k = 0; k < live; k++)
               energies = {energies, VAL_W'($urandom())};
            if (style != 9)
               energies.sort();
            if (style == 8) begin
               for (int k = 1; k < live; k++)
                  if ($urandom_range(0, 2) == 0)
                     energies[k] = energies[k - 1];
            end
         end

         descending = 1'($urandom_range(0, 1));
         for (int k = 0; k < live; k++) begin
            idx = descending ? live - 1 - k : k;
            send_item(make_load(idx, energies[idx], random_flux()));
            sent++;
         end

         n_queries = $urandom_range(4, 16);
         for (int k = 0; k < n_queries; k++) begin
            pick = $urandom_range(0, 19);
            // Now and then hold off until the block has caught up.
            if (pick == 0)
               drain_results();
            if (pick <= 2) begin
               // Reload any slot; half of the live ones keep their energy and change flux only.
               idx = $urandom_range(0, TABLE_DEPTH - 1);
               if (idx < live && $urandom_range(0, 1) == 1)
                  send_item(make_load(idx, knot_energy[idx], random_flux()));
               else
                  send_item(make_load(idx, $urandom(), random_flux()));
            end else begin
               if (live == 0)
                  probe = $urandom();
               else begin
                  idx = $urandom_range(0, live - 1);
                  case ($urandom_range(0, 9))
                     0, 1, 2: begin
                        probe = knot_energy[idx];
                     end
                     3, 4, 5, 6: begin
                        // Somewhere from this entry up to its successor.
                        lo = knot_energy[idx];
                        hi = (idx + 1 < live) ? knot_energy[idx + 1] : 32'hFFFF_FFFF;
                        probe = (hi > lo) ? $urandom_range(hi, lo)
                                          : lo ^ VAL_W'($urandom_range(0, 255));
                     end
                     7: begin
                        probe = $urandom_range(knot_energy[0], 0);
                     end
                     8: begin
                        probe = $urandom_range(32'hFFFF_FFFF, knot_energy[live - 1]);
                     end
                     default: begin
                        probe = $urandom();
                     end
                  endcase
               end
               send_item(make_query(probe));
            end
            sent++;
         end
         phase++;
      end
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_single_entry();
      test_interpolation();
      test_saturation();
      test_segment_shapes();
      test_random_tables();
      drain_results();
      if (error_count == 0)
         $display("PASS table_linear_interpolator");
      else
         $display("FAIL table_linear_interpolator");
      $finish;
   end

endmodule
